// ===== src/tha_pkg.sv =====
package tha_pkg;

    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STEPS    = 16;

    localparam int TBL_FRAC  = 16;
    localparam int TBL_LEN   = 24;
    localparam int NUM_CELLS = (CORDIC_STEPS < TBL_LEN) ? CORDIC_STEPS : TBL_LEN;
    localparam int IDX_W     = $clog2(TBL_LEN);
    localparam int OP_SCALE  = 8;

    // prep operand width, CORDIC datapath width, angle accumulator width
    localparam int PW = 26;
    localparam int CW = 36;
    localparam int ZW = 26;

    localparam int SQ_IN_W   = 48;
    localparam int SQ_ROOT_W = 24;
    localparam int SQ_REM_W  = 27;
    localparam int SQ_CNT_W  = $clog2(SQ_ROOT_W);

    localparam int OUT_SHIFT = TBL_FRAC - ANGLE_FRAC_BITS;

    localparam logic signed [ZW-1:0] Z90    = ZW'(90 << TBL_FRAC);
    localparam logic signed [ZW-1:0] Z180   = ZW'(180 << TBL_FRAC);
    localparam logic signed [ZW-1:0] RND    = ZW'(1 << (OUT_SHIFT - 1));
    localparam logic signed [ZW-1:0] LIM90  = ZW'(90 << ANGLE_FRAC_BITS);
    localparam logic signed [ZW-1:0] LIM180 = ZW'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [ZW-1:0] FULL   = ZW'(360 << ANGLE_FRAC_BITS);

    localparam logic [1:0] KIND_ROLL  = 2'd0;
    localparam logic [1:0] KIND_HEAD  = 2'd1;
    localparam logic [1:0] KIND_PITCH = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic [1:0]           kind;
        logic                 hold;   // result already known, cells pass z through
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } token_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic signed [ZW-1:0] atan_entry(input logic [IDX_W-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = ZW'(2949120);
            5'd1:    v = ZW'(1740967);
            5'd2:    v = ZW'(919879);
            5'd3:    v = ZW'(466945);
            5'd4:    v = ZW'(234378);
            5'd5:    v = ZW'(117304);
            5'd6:    v = ZW'(58666);
            5'd7:    v = ZW'(29335);
            5'd8:    v = ZW'(14668);
            5'd9:    v = ZW'(7334);
            5'd10:   v = ZW'(3667);
            5'd11:   v = ZW'(1833);
            5'd12:   v = ZW'(917);
            5'd13:   v = ZW'(458);
            5'd14:   v = ZW'(229);
            5'd15:   v = ZW'(115);
            5'd16:   v = ZW'(57);
            5'd17:   v = ZW'(29);
            5'd18:   v = ZW'(14);
            5'd19:   v = ZW'(7);
            5'd20:   v = ZW'(4);
            5'd21:   v = ZW'(2);
            5'd22:   v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/tilt_and_heading_angles.sv =====
// Channel  Dir  tdata (low bit up)                          tuser
// s_       in   accel_x, accel_y, accel_z, mag_x, mag_y     mag_valid
// m_       out  roll_angle, pitch_angle, heading_angle, pad -
//
// One sample at a time: registered squares, a bit-serial square root,
// then the pitch vector runs down the 16-cell CORDIC row; roll and
// heading go through the row first.
// aresetn is synchronous: the held heading clears to 0, no result pending.
// A new request is taken while the last result waits on m_tready; the
// finished result then waits until the output register is free.
module tilt_and_heading_angles (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // accel_x, accel_y, accel_z, mag_x, mag_y
    input  logic        s_tuser,   // mag_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // roll_angle, pitch_angle, heading_angle, zero pad
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int PW = tha_pkg::PW;
    localparam int CW = tha_pkg::CW;
    localparam int ZW = tha_pkg::ZW;
    localparam int N  = tha_pkg::NUM_CELLS;

    logic [1:0]          st_reg, st_next;
    logic [1:0]          ph_reg, ph_next;
    logic signed [15:0]  ax_reg, ay_reg, az_reg, mx_reg, my_reg;
    logic                magv_reg;
    logic [31:0]         sqa_reg, sqb_reg;
    logic signed [31:0]  sqa_s, sqb_s;
    logic [15:0]         roll_reg, roll_next;
    logic [14:0]         pitch_reg, pitch_next;
    logic [15:0]         head_reg, head_next;
    logic [15:0]         held_reg, held_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [47:0]         m_tdata_reg, m_tdata_next;

    logic                       accept, slot_free;
    logic                       sq_start, sq_done;
    logic [31:0]                sq_sum;
    logic [tha_pkg::SQ_ROOT_W-1:0] sq_root;

    logic signed [PW-1:0] py, px;
    logic signed [CW-1:0] x36, y36;
    logic [1:0]           inj_kind;
    logic                 inj_valid;
    tha_pkg::token_t      tok [N+1];
    tha_pkg::token_t      inj;

    logic signed [ZW-1:0] zsum, rnd, lim;
    tha_pkg::token_t      res;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (st_reg == ST_IDLE);
    assign slot_free = !m_tvalid_reg || m_tready;

    // squares for the pitch denominator, one stage ahead of the root
    assign sqa_s    = ay_reg * ay_reg;
    assign sqb_s    = az_reg * az_reg;
    assign sq_sum   = sqa_reg + sqb_reg;
    assign sq_start = (st_reg == ST_RUN) && (ph_reg == 2'd1);

    tha_isqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .value   ({sq_sum, 16'b0}),
        .done    (sq_done),
        .root    (sq_root)
    );

    // pick the vector entering the cell row
    always_comb begin
        inj_valid = 1'b0;
        inj_kind  = tha_pkg::KIND_ROLL;
        py        = PW'(ay_reg);
        px        = PW'(az_reg);
        if (st_reg == ST_RUN) begin
            if (ph_reg == 2'd0) begin
                inj_valid = 1'b1;
            end else if (ph_reg == 2'd1) begin
                inj_valid = 1'b1;
                inj_kind  = tha_pkg::KIND_HEAD;
                py        = PW'(my_reg);
                px        = PW'(mx_reg);
            end else if (sq_done) begin
                inj_valid = 1'b1;
                inj_kind  = tha_pkg::KIND_PITCH;
                py        = -(PW'(ax_reg) <<< tha_pkg::OP_SCALE);
                px        = $signed({2'b00, sq_root});
            end
        end
    end

    // axis cases, then quadrant fold for a negative x
    always_comb begin
        x36 = {{(CW-PW-tha_pkg::OP_SCALE){px[PW-1]}}, px, {tha_pkg::OP_SCALE{1'b0}}};
        y36 = {{(CW-PW-tha_pkg::OP_SCALE){py[PW-1]}}, py, {tha_pkg::OP_SCALE{1'b0}}};
        inj.valid = inj_valid;
        inj.kind  = inj_kind;
        inj.hold  = 1'b0;
        inj.x     = x36;
        inj.y     = y36;
        inj.z     = '0;
        if (py == 0) begin
            inj.hold = 1'b1;
            inj.z    = (px < 0) ? tha_pkg::Z180 : '0;
        end else if (px == 0) begin
            inj.hold = 1'b1;
            inj.z    = (py > 0) ? tha_pkg::Z90 : -tha_pkg::Z90;
        end else if (px < 0) begin
            if (py >= 0) begin
                inj.x = y36;
                inj.y = -x36;
                inj.z = tha_pkg::Z90;
            end else begin
                inj.x = -y36;
                inj.y = x36;
                inj.z = -tha_pkg::Z90;
            end
        end
    end

    assign tok[0] = inj;

    for (genvar g = 0; g < N; g++) begin : g_cell
        tha_cordic_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .step_idx (tha_pkg::IDX_W'(g)),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1])
        );
    end

    assign res = tok[N];

    // round half up, then clamp by angle kind; a negative heading wraps first
    always_comb begin
        zsum = res.z + tha_pkg::RND;
        rnd  = zsum >>> tha_pkg::OUT_SHIFT;
        lim  = rnd;
        case (res.kind)
            tha_pkg::KIND_ROLL: begin
                if (rnd < -tha_pkg::LIM180) lim = -tha_pkg::LIM180;
                if (rnd > tha_pkg::LIM180)  lim = tha_pkg::LIM180;
            end
            tha_pkg::KIND_PITCH: begin
                if (rnd < -tha_pkg::LIM90) lim = -tha_pkg::LIM90;
                if (rnd > tha_pkg::LIM90)  lim = tha_pkg::LIM90;
            end
            default: begin
                if (rnd < 0) lim = rnd + tha_pkg::FULL;
                if (lim < 0) lim = '0;
                if (lim > tha_pkg::FULL) lim = tha_pkg::FULL;
            end
        endcase
    end

    always_comb begin
        st_next       = st_reg;
        ph_next       = ph_reg;
        roll_next     = roll_reg;
        pitch_next    = pitch_reg;
        head_next     = head_reg;
        held_next     = held_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (res.valid) begin
            case (res.kind)
                tha_pkg::KIND_ROLL:  roll_next  = lim[15:0];
                tha_pkg::KIND_PITCH: pitch_next = lim[14:0];
                default:             head_next  = lim[15:0];
            endcase
        end
        unique case (st_reg)
            ST_IDLE: begin
                if (accept) begin
                    st_next = ST_RUN;
                    ph_next = 2'd0;
                end
            end
            ST_RUN: begin
                if (ph_reg != 2'd2) ph_next = ph_reg + 2'd1;
                if (res.valid && res.kind == tha_pkg::KIND_PITCH) st_next = ST_DONE;
            end
            ST_DONE: begin
                if (slot_free) begin
                    if (magv_reg) held_next = head_reg;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, (magv_reg ? head_reg : held_reg),
                                     pitch_reg, roll_reg};
                    st_next       = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            ph_reg       <= 2'd0;
            held_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            st_reg       <= st_next;
            ph_reg       <= ph_next;
            held_reg     <= held_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (accept) begin
            ax_reg   <= s_tdata[15:0];
            ay_reg   <= s_tdata[31:16];
            az_reg   <= s_tdata[47:32];
            mx_reg   <= s_tdata[63:48];
            my_reg   <= s_tdata[79:64];
            magv_reg <= s_tuser;
        end
        sqa_reg     <= sqa_s;
        sqb_reg     <= sqb_s;
        roll_reg    <= roll_next;
        pitch_reg   <= pitch_next;
        head_reg    <= head_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // nothing leaves the cell row unless a sample is in progress
    a_row_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> (st_reg == ST_RUN))
        else $error("cell row output outside a run");

    // the root finishes only after the vector injections of this sample
    a_root_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_done |-> (st_reg == ST_RUN) && (ph_reg == 2'd2))
        else $error("square root done out of phase");

    // a finished sample always produces an output beat
    a_done_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_DONE) && slot_free |=> m_tvalid && (st_reg == ST_IDLE))
        else $error("completed sample not presented");

endmodule

// ===== src/tha_cordic_cell.sv =====
module tha_cordic_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [tha_pkg::IDX_W-1:0]   step_idx,
    input  tha_pkg::token_t             tok_in,
    output tha_pkg::token_t             tok_out
);

    tha_pkg::token_t tok_reg, tok_next;
    logic signed [tha_pkg::CW-1:0] cur_x, cur_y, xs, ys;
    logic signed [tha_pkg::ZW-1:0] cur_z, ang;

    always_comb begin
        cur_x = tok_in.x;
        cur_y = tok_in.y;
        cur_z = tok_in.z;
        xs    = cur_x >>> step_idx;
        ys    = cur_y >>> step_idx;
        ang   = tha_pkg::atan_entry(step_idx);
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.hold) begin
            if (cur_y >= 0) begin
                tok_next.x = cur_x + ys;
                tok_next.y = cur_y - xs;
                tok_next.z = cur_z + ang;
            end else begin
                tok_next.x = cur_x - ys;
                tok_next.y = cur_y + xs;
                tok_next.z = cur_z - ang;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== src/tha_isqrt.sv =====
module tha_isqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [tha_pkg::SQ_IN_W-1:0]     value,
    output logic                            done,
    output logic [tha_pkg::SQ_ROOT_W-1:0]   root
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [tha_pkg::SQ_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [tha_pkg::SQ_IN_W-1:0]       val_reg, val_next;
    logic [tha_pkg::SQ_REM_W-1:0]      rem_reg, rem_next;
    logic [tha_pkg::SQ_ROOT_W-1:0]     root_reg, root_next;
    logic [tha_pkg::SQ_REM_W-1:0]      rem_sh, trial;

    // one root bit per cycle, two radicand bits shifted in each step
    always_comb begin
        rem_sh    = {rem_reg[tha_pkg::SQ_REM_W-3:0],
                     val_reg[tha_pkg::SQ_IN_W-1 -: 2]};
        trial     = tha_pkg::SQ_REM_W'({root_reg, 2'b01});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            val_next = {val_reg[tha_pkg::SQ_IN_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[tha_pkg::SQ_ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[tha_pkg::SQ_ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tha_pkg::SQ_CNT_W'(tha_pkg::SQ_ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== bench/tilt_and_heading_angles_tb.sv =====
module tilt_and_heading_angles_tb;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic               mag_ok;
    } sample_t;

    typedef struct {
        logic [15:0] roll;
        logic [14:0] pitch;
        logic [15:0] heading;
    } angles_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // accel_x, accel_y, accel_z, mag_x, mag_y
    logic        s_tuser;   // mag_valid
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // roll_angle, pitch_angle, heading_angle, zero pad

    angles_t     pending_angles[$];
    logic [15:0] heading_now;
    int          err_count;
    int          burst_left;
    angles_t     got_angles;
    angles_t     want_angles;

    tilt_and_heading_angles dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tilt_and_heading_angles_tb: errors");
        $finish;
    end

    // ---------------- predictor ----------------

    // atan(2^-i) in 2^-16 degree
    function automatic longint atan_step(int i);
        case (i)
            0:  return 2949120;
            1:  return 1740967;
            2:  return 919879;
            3:  return 466945;
            4:  return 234378;
            5:  return 117304;
            6:  return 58666;
            7:  return 29335;
            8:  return 14668;
            9:  return 7334;
            10: return 3667;
            11: return 1833;
            12: return 917;
            13: return 458;
            14: return 229;
            15: return 115;
            16: return 57;
            17: return 29;
            18: return 14;
            19: return 7;
            20: return 4;
            21: return 2;
            22: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned probe;
        res = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= res + probe) begin
                v = v - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return longint'(res);
    endfunction

    // atan2(y, x) in 2^-16 degree, vectoring mode
    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint t;
        longint xs;
        longint ys;
        int     i;
        z = 0;
        if (y == 0) return (x < 0) ? (longint'(180) <<< tha_pkg::TBL_FRAC) : 0;
        if (x == 0) return (y > 0) ? (longint'(90) <<< tha_pkg::TBL_FRAC)
                                   : -(longint'(90) <<< tha_pkg::TBL_FRAC);
        x = x * (longint'(1) <<< tha_pkg::OP_SCALE);
        y = y * (longint'(1) <<< tha_pkg::OP_SCALE);
        // left half plane: pre-rotate by a quarter turn
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = longint'(90) <<< tha_pkg::TBL_FRAC;
            end else begin
                x = -y;
                y = t;
                z = -(longint'(90) <<< tha_pkg::TBL_FRAC);
            end
        end
        for (i = 0; i < tha_pkg::CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint round_angle(longint z);
        int s;
        s = tha_pkg::TBL_FRAC - tha_pkg::ANGLE_FRAC_BITS;
        return (z + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_deg(longint a, longint lo_deg, longint hi_deg);
        longint lo;
        longint hi;
        lo = lo_deg * (longint'(1) <<< tha_pkg::ANGLE_FRAC_BITS);
        hi = hi_deg * (longint'(1) <<< tha_pkg::ANGLE_FRAC_BITS);
        if (a < lo) a = lo;
        if (a > hi) a = hi;
        return a;
    endfunction

    // updates heading_now, so call once per accepted request, in order
    function automatic angles_t predict_angles(sample_t smp);
        angles_t res;
        longint  ax;
        longint  ay;
        longint  az;
        longint  roll;
        longint  pitch;
        longint  h;
        longint  full;
        longint  mag;
        ax = longint'(smp.ax);
        ay = longint'(smp.ay);
        az = longint'(smp.az);
        roll = clamp_deg(round_angle(vector_angle(ay, az)), -180, 180);
        mag = root_floor(longint'(ay * ay + az * az) <<< 16);
        pitch = clamp_deg(round_angle(vector_angle(-ax * (longint'(1) <<< tha_pkg::OP_SCALE),
                                                   mag)),
                          -90, 90);
        if (smp.mag_ok) begin
            full = longint'(360) * (longint'(1) <<< tha_pkg::ANGLE_FRAC_BITS);
            h = round_angle(vector_angle(longint'(smp.my), longint'(smp.mx)));
            if (h < 0) h = h + full;
            if (h < 0) h = 0;
            if (h > full) h = full;
            heading_now = h[15:0];
        end
        res.roll    = roll[15:0];
        res.pitch   = pitch[14:0];
        res.heading = heading_now;
        return res;
    endfunction

    // ---------------- result checking ----------------

    task automatic note_mismatch(string what, logic [15:0] want_v, logic [15:0] got_v);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s mismatch, expected %h got %h", $time, what, want_v, got_v);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_angles.roll    = m_tdata[15:0];
            got_angles.pitch   = m_tdata[30:16];
            got_angles.heading = m_tdata[46:31];
            if (pending_angles.size() == 0) begin
                note_mismatch("unexpected result", 16'h0, m_tdata[15:0]);
            end else begin
                want_angles = pending_angles.pop_front();
                if (got_angles.roll !== want_angles.roll)
                    note_mismatch("roll", want_angles.roll, got_angles.roll);
                if (got_angles.pitch !== want_angles.pitch)
                    note_mismatch("pitch", {1'b0, want_angles.pitch},
                                  {1'b0, got_angles.pitch});
                if (got_angles.heading !== want_angles.heading)
                    note_mismatch("heading", want_angles.heading, got_angles.heading);
            end
        end
    end

    // receiver: stall behavior switches between a few modes
    initial begin
        int stall_mode;
        int stretch;
        m_tready = 1'b0;
        stall_mode = 0;
        stretch = 0;
        forever begin
            @(negedge aclk);
            if (stretch == 0) begin
                stall_mode = $urandom_range(0, 3);
                stretch = $urandom_range(32, 256);
            end
            stretch--;
            case (stall_mode)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 1) == 1);
                2: m_tready = ($urandom_range(0, 3) == 0);
                default: m_tready = ($urandom_range(0, 15) != 0) ? m_tready : ~m_tready;
            endcase
        end
    end

    // ---------------- stimulus ----------------

    function automatic sample_t make_sample(int ax, int ay, int az, int mx, int my, bit ok);
        sample_t smp;
        smp.ax = ax[15:0];
        smp.ay = ay[15:0];
        smp.az = az[15:0];
        smp.mx = mx[15:0];
        smp.my = my[15:0];
        smp.mag_ok = ok;
        return smp;
    endfunction

    // enters and leaves at a falling edge
    task automatic send_sample(sample_t smp);
        int gap;
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        s_tdata  = {smp.my, smp.mx, smp.az, smp.ay, smp.ax};
        s_tuser  = smp.mag_ok;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_angles.push_back(predict_angles(smp));
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_angles.size() != 0) @(negedge aclk);
    endtask

    task automatic test_zero_and_axes();
        send_sample(make_sample(0, 0, 0, 0, 0, 1'b0));          // heading still at reset
        send_sample(make_sample(0, 0, 16384, 16384, 0, 1'b1));
        send_sample(make_sample(0, 0, -16384, -100, 0, 1'b1));  // roll and heading at 180
        send_sample(make_sample(0, 16384, 0, 0, 500, 1'b1));
        send_sample(make_sample(0, -16384, 0, 0, -500, 1'b1));  // heading wraps to 270
        send_sample(make_sample(32767, 0, 0, 0, 0, 1'b1));      // pitch over zero magnitude
        send_sample(make_sample(-32768, 0, 0, 0, 0, 1'b0));
        send_sample(make_sample(0, 0, 0, 0, 0, 1'b1));
    endtask

    task automatic test_extremes();
        send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, 1'b1));
        send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 1'b1));
        send_sample(make_sample(32767, -32768, 32767, -32768, 32767, 1'b1));
        send_sample(make_sample(-32768, 32767, -32768, 32767, -32768, 1'b1));
        send_sample(make_sample(-1000, 500, -1000, -300, 200, 1'b1));
        send_sample(make_sample(1000, -500, -1000, -300, -200, 1'b1));
        // near the +-180 seam: rounding may overshoot before the clamp
        send_sample(make_sample(1, -1, -32768, -32768, -1, 1'b1));
        send_sample(make_sample(-1, 1, -32768, 32767, -1, 1'b1));
        send_sample(make_sample(1, 1, -1, 1, 1, 1'b1));
    endtask

    task automatic test_heading_hold();
        send_sample(make_sample(200, 300, 16000, 1234, -4321, 1'b1));
        send_sample(make_sample(-200, -300, 16000, -9999, 7777, 1'b0));
        send_sample(make_sample(0, 0, 0, 32767, 32767, 1'b0));
        send_sample(make_sample(5, 6, 7, -1, 0, 1'b1));
        send_sample(make_sample(5, 6, 7, 0, 0, 1'b0));
        drain_results();
        send_sample(make_sample(8, 9, 10, 0, 0, 1'b1));         // magnetometer all zero
    endtask

    function automatic logic [15:0] random_axis(int kind);
        int pick;
        case (kind)
            1: return 16'($urandom_range(0, 128) - 64);
            2: begin
                pick = $urandom_range(0, 5);
                case (pick)
                    0: return 16'h8000;
                    1: return 16'h8001;
                    2: return 16'hFFFF;
                    3: return 16'h0000;
                    4: return 16'h0001;
                    default: return 16'h7FFF;
                endcase
            end
            3: return ($urandom_range(0, 1) == 1) ? 16'h0000 : 16'($urandom());
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic test_random(int count);
        sample_t smp;
        int      kind;
        int      n;
        for (n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            if (kind == 6) begin
                // device roughly level or upside down
                smp.ax = random_axis(1);
                smp.ay = random_axis(1);
                smp.az = 16'(($urandom_range(0, 1) == 1 ? 16384 : -16384) +
                             $urandom_range(0, 256) - 128);
                smp.mx = 16'($urandom_range(0, 2000) - 1000);
                smp.my = 16'($urandom_range(0, 2000) - 1000);
            end else begin
                kind = (kind < 4 || kind == 9) ? 0 : (kind - 3 > 3 ? 3 : kind - 3);
                smp.ax = random_axis(kind);
                smp.ay = random_axis(kind);
                smp.az = random_axis(kind);
                smp.mx = random_axis(kind);
                smp.my = random_axis(kind);
            end
            smp.mag_ok = ($urandom_range(0, 9) < 7);
            send_sample(smp);
            if (n == count / 2) drain_results();
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        heading_now = '0;
        err_count   = 0;
        burst_left  = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_zero_and_axes();
        test_extremes();
        drain_results();
        test_heading_hold();
        test_random(1000);

        drain_results();
        repeat (100) @(posedge aclk);
        if (err_count == 0) begin
            $display("tilt_and_heading_angles_tb: clean");
        end else begin
            $display("tilt_and_heading_angles_tb: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tha_pkg.sv
src/tha_cordic_cell.sv
src/tha_isqrt.sv
src/tilt_and_heading_angles.sv
bench/tilt_and_heading_angles_tb.sv
